// ===== rtl/ppc_pkg.sv =====
// ----------------------------------------------------------------------------
// ppc_pkg
// Shared types, widths and constants of the positional PID controller.
// ----------------------------------------------------------------------------
package ppc_pkg;

  // configuration register indexes
  localparam logic [2:0] REG_PROP_GAIN   = 3'd0;
  localparam logic [2:0] REG_INTEG_GAIN  = 3'd1;
  localparam logic [2:0] REG_DERIV_GAIN  = 3'd2;
  localparam logic [2:0] REG_STEP_TIME   = 3'd3;
  localparam logic [2:0] REG_INTEG_LIMIT = 3'd4;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam int GAIN_W     = 24;
  localparam int DT_W       = 12;
  localparam int LIMIT_W    = 16;
  localparam int IN_W       = 16;
  localparam int OUT_W      = 48;

  localparam logic [DT_W-1:0]    STEP_TIME_RESET   = 12'd256;
  localparam logic [LIMIT_W-1:0] INTEG_LIMIT_RESET = 16'd9000;

  // shared multiplier: signed operand a, unsigned operand b
  localparam int MUL_A_W = 30;
  localparam int MUL_B_W = GAIN_W;
  localparam int PROD_W  = MUL_A_W + MUL_B_W + 1;

  // divider: signed dividend, two quotient bits per cycle
  localparam int DIVIDEND_W = 50;
  localparam int DIV_ITER   = DIVIDEND_W / 2;
  localparam int DIV_CNT_W  = $clog2(DIV_ITER);

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

// ===== rtl/pid_position_controller.sv =====
// ----------------------------------------------------------------------------
// pid_position_controller
// Positional PID step with clamped integral and saturated output.
// ----------------------------------------------------------------------------
// item_stall stays high from the acceptance of an item until its result is
// offered. Four products go one after another through a single registered
// multiplier (proportional term, error times dt, integral increment,
// derivative numerator), then the derivative is divided by dt in an
// iterative divider producing two quotient bits per cycle. The result sits
// in an output register, so a new item is taken while it waits. A
// step_time of zero is handled as one.
module pid_position_controller (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_write,
  input  logic [ppc_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [ppc_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  logic                                 item_valid,
  output logic                                 item_stall,
  input  logic signed [ppc_pkg::IN_W-1:0]      setpoint,
  input  logic signed [ppc_pkg::IN_W-1:0]      measured,
  output logic                                 result_valid,
  input  logic                                 result_stall,
  output logic signed [ppc_pkg::OUT_W-1:0]     control_out
);
  import ppc_pkg::*;

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_MUL_P   = 3'd1;
  localparam logic [2:0] ST_MUL_EDT = 3'd2;
  localparam logic [2:0] ST_MUL_I   = 3'd3;
  localparam logic [2:0] ST_MUL_D   = 3'd4;
  localparam logic [2:0] ST_CLAMP   = 3'd5;
  localparam logic [2:0] ST_DIV     = 3'd6;
  localparam logic [2:0] ST_FINISH  = 3'd7;

  localparam int SUM_W = 52;

  // configuration
  logic [GAIN_W-1:0]  prop_gain;
  logic [GAIN_W-1:0]  integ_gain;
  logic [GAIN_W-1:0]  deriv_gain;
  logic [DT_W-1:0]    step_time;
  logic [LIMIT_W-1:0] integ_limit;

  // controller state
  logic signed [16:0] prev_error;
  logic signed [25:0] integ_acc;

  logic [2:0]               state;
  logic signed [16:0]       err;
  logic signed [17:0]       err_delta;
  logic signed [40:0]       pterm;
  logic signed [47:0]       acc_sum;
  logic signed [SUM_W-1:0]  total;

  logic [DT_W-1:0]               dt_eff;
  logic signed [MUL_A_W-1:0]     mul_a;
  logic [MUL_B_W-1:0]            mul_b;
  logic signed [PROD_W-1:0]      prod;
  logic signed [PROD_W-1:0]      inc_adj;
  logic signed [47:0]            lim48;
  logic signed [25:0]            lim26;
  logic signed [25:0]            acc_clamped;
  logic signed [16:0]            err_next;
  logic                          div_start;
  logic signed [DIVIDEND_W-1:0]  div_dividend;
  logic signed [DIVIDEND_W-1:0]  div_quotient;
  div_status_t                   div_st;
  logic signed [OUT_W-1:0]       sat_out;
  logic                          item_take;

  assign item_stall = (state != ST_IDLE);
  assign item_take  = item_valid && !item_stall;
  assign dt_eff     = (step_time == '0) ? DT_W'(1) : step_time;
  assign err_next   = {setpoint[IN_W-1], setpoint} - {measured[IN_W-1], measured};

  // operand selection for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      ST_MUL_P: begin
        mul_a = MUL_A_W'(err);
        mul_b = prop_gain;
      end
      ST_MUL_EDT: begin
        mul_a = MUL_A_W'(err);
        mul_b = MUL_B_W'(dt_eff);
      end
      ST_MUL_I: begin
        mul_a = prod[MUL_A_W-1:0];
        mul_b = integ_gain;
      end
      ST_MUL_D: begin
        mul_a = MUL_A_W'(err_delta);
        mul_b = deriv_gain;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  ppc_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  // increment / 256 rounded toward zero
  assign inc_adj = prod + (prod[PROD_W-1] ? PROD_W'(255) : PROD_W'(0));

  assign lim48 = $signed({24'd0, integ_limit, 8'd0});
  assign lim26 = $signed({2'd0, integ_limit, 8'd0});

  always_comb begin
    if (acc_sum > lim48) begin
      acc_clamped = lim26;
    end else if (acc_sum < -lim48) begin
      acc_clamped = -lim26;
    end else begin
      acc_clamped = acc_sum[25:0];
    end
  end

  assign div_start    = (state == ST_CLAMP);
  assign div_dividend = $signed({prod[41:0], 8'd0});

  ppc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (dt_eff),
    .quotient (div_quotient),
    .status   (div_st)
  );

  // saturate to the output range
  always_comb begin
    if (total[SUM_W-1:OUT_W-1] == '0 || total[SUM_W-1:OUT_W-1] == '1) begin
      sat_out = total[OUT_W-1:0];
    end else if (total[SUM_W-1]) begin
      sat_out = {1'b1, {(OUT_W-1){1'b0}}};
    end else begin
      sat_out = {1'b0, {(OUT_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prop_gain   <= '0;
      integ_gain  <= '0;
      deriv_gain  <= '0;
      step_time   <= STEP_TIME_RESET;
      integ_limit <= INTEG_LIMIT_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_PROP_GAIN:   prop_gain   <= cfg_data[GAIN_W-1:0];
        REG_INTEG_GAIN:  integ_gain  <= cfg_data[GAIN_W-1:0];
        REG_DERIV_GAIN:  deriv_gain  <= cfg_data[GAIN_W-1:0];
        REG_STEP_TIME:   step_time   <= cfg_data[DT_W-1:0];
        REG_INTEG_LIMIT: integ_limit <= cfg_data[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      result_valid <= 1'b0;
      prev_error   <= '0;
      integ_acc    <= '0;
    end else begin
      // the finish step reloads the output register itself
      if (result_valid && !result_stall && state != ST_FINISH) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (item_take) begin
            state <= ST_MUL_P;
          end
        end
        ST_MUL_P:   state <= ST_MUL_EDT;
        ST_MUL_EDT: state <= ST_MUL_I;
        ST_MUL_I:   state <= ST_MUL_D;
        ST_MUL_D:   state <= ST_CLAMP;
        ST_CLAMP: begin
          integ_acc  <= acc_clamped;
          prev_error <= err;
          state      <= ST_DIV;
        end
        ST_DIV: begin
          if (div_st.done) begin
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (!result_valid || !result_stall) begin
            result_valid <= 1'b1;
            state        <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (item_take) begin
      err       <= err_next;
      err_delta <= 18'(err_next) - 18'(prev_error);
    end
    if (state == ST_MUL_EDT) begin
      pterm <= prod[40:0];
    end
    if (state == ST_MUL_D) begin
      acc_sum <= 48'(integ_acc) + 48'($signed(inc_adj[PROD_W-1:8]));
    end
    if (state == ST_DIV && div_st.done) begin
      total <= SUM_W'(pterm) + SUM_W'(integ_acc) + SUM_W'(div_quotient);
    end
    if (state == ST_FINISH && (!result_valid || !result_stall)) begin
      control_out <= sat_out;
    end
  end

`ifndef NO_ASSERTIONS
  a_result_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(state) == ST_FINISH)
    else $error("result raised outside the finish step");

  a_div_idle: assert property (@(posedge clk) disable iff (rst)
    state == ST_IDLE |-> !div_st.busy)
    else $error("divider busy while controller idle");

  a_take_starts: assert property (@(posedge clk) disable iff (rst)
    item_take |=> state == ST_MUL_P)
    else $error("accepted item did not start the sequence");
`endif

endmodule

// ===== rtl/ppc_mul.sv =====
// ----------------------------------------------------------------------------
// ppc_mul
// Shared signed-by-unsigned multiplier with a registered product.
// ----------------------------------------------------------------------------
module ppc_mul (
  input  logic                                clk,
  input  logic signed [ppc_pkg::MUL_A_W-1:0]  a,
  input  logic        [ppc_pkg::MUL_B_W-1:0]  b,
  output logic signed [ppc_pkg::PROD_W-1:0]   prod
);
  import ppc_pkg::*;

  logic signed [MUL_B_W:0] b_ext;

  assign b_ext = $signed({1'b0, b});

  always_ff @(posedge clk) begin
    prod <= a * b_ext;
  end

endmodule

// ===== rtl/ppc_div.sv =====
// ----------------------------------------------------------------------------
// ppc_div
// Iterative restoring divider, signed dividend by unsigned non-zero divisor,
// two quotient bits per cycle, quotient truncated toward zero.
// ----------------------------------------------------------------------------
module ppc_div (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  input  logic signed [ppc_pkg::DIVIDEND_W-1:0] dividend,
  input  logic        [ppc_pkg::DT_W-1:0]       divisor,
  output logic signed [ppc_pkg::DIVIDEND_W-1:0] quotient,
  output ppc_pkg::div_status_t                  status
);
  import ppc_pkg::*;

  logic [DT_W:0]          rem;
  logic [DIVIDEND_W-1:0]  quo;
  logic [DT_W-1:0]        dsr;
  logic                   neg;
  logic [DIV_CNT_W-1:0]   cnt;
  logic                   busy;
  logic                   done;

  logic [DT_W:0]          rem_next;
  logic [DIVIDEND_W-1:0]  quo_next;

  // two dependent shift-subtract steps
  always_comb begin
    rem_next = rem;
    quo_next = quo;
    for (int k = 0; k < 2; k++) begin
      rem_next = {rem_next[DT_W-1:0], quo_next[DIVIDEND_W-1]};
      quo_next = {quo_next[DIVIDEND_W-2:0], 1'b0};
      if (rem_next >= {1'b0, dsr}) begin
        rem_next    = rem_next - {1'b0, dsr};
        quo_next[0] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == DIV_CNT_W'(DIV_ITER - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg <= dividend[DIVIDEND_W-1];
      quo <= dividend[DIVIDEND_W-1] ? DIVIDEND_W'(-dividend) : DIVIDEND_W'(dividend);
      rem <= '0;
      dsr <= divisor;
    end else if (busy) begin
      quo <= quo_next;
      rem <= rem_next;
    end
  end

  assign quotient    = neg ? -$signed(quo) : $signed(quo);
  assign status.busy = busy;
  assign status.done = done;

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives setpoint and measurement items into the PID controller through the
// valid/stall handshake, with random gaps and output stalls. A predictor
// works out each control output from the gains, dt and limit held here, and
// the output is compared in order. Directed cases cover the field extremes,
// integral clamping, derivative saturation, a zero dt and register masking.
// Random phases with fresh settings follow.
// ----------------------------------------------------------------------------
module testbench;
  import ppc_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam longint OUT_MAX = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint OUT_MIN = -OUT_MAX - 1;
  localparam logic [CFG_IDX_W-1:0] REG_NONE = 3'd7;
  localparam logic [GAIN_W-1:0] GAIN_MAX = 24'hFF_FFFF;
  localparam logic signed [IN_W-1:0] IN_MAX = 16'sh7FFF;
  localparam logic signed [IN_W-1:0] IN_MIN = 16'sh8000;

  logic                           clk;
  logic                           rst = 1'b1;
  logic                           cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]           cfg_index = '0;
  logic [CFG_DATA_W-1:0]          cfg_data = '0;
  logic                           item_valid = 1'b0;
  logic                           item_stall;
  logic signed [IN_W-1:0]         setpoint = '0;
  logic signed [IN_W-1:0]         measured = '0;
  logic                           result_valid;
  logic                           result_stall = 1'b0;
  logic signed [OUT_W-1:0]        control_out;

  // copy of the controller settings and state
  logic [GAIN_W-1:0]  gain_p, gain_i, gain_d;
  logic [DT_W-1:0]    dt_q8;
  logic [LIMIT_W-1:0] integ_bound;
  longint             err_prev;
  longint             integ_q8;

  logic signed [OUT_W-1:0] control_expected_q[$];
  int  error_count = 0;
  int  cycle_count = 0;
  bit  quiet = 1'b0;

  pid_position_controller u_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .setpoint     (setpoint),
    .measured     (measured),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .control_out  (control_out)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic logic signed [OUT_W-1:0] next_control(
    input logic signed [IN_W-1:0] sp,
    input logic signed [IN_W-1:0] ms
  );
    longint err, dt_eff, lim, p_term, acc, d_term, total;
    err    = longint'(sp) - longint'(ms);
    dt_eff = (dt_q8 == '0) ? 64'sd1 : longint'(dt_q8);
    lim    = longint'(integ_bound) * 256;
    p_term = longint'(gain_p) * err;
    acc    = integ_q8 + (longint'(gain_i) * err * dt_eff) / 256;
    if (acc > lim) acc = lim;
    else if (acc < -lim) acc = -lim;
    integ_q8 = acc;
    d_term   = (longint'(gain_d) * (err - err_prev) * 256) / dt_eff;
    err_prev = err;
    total    = p_term + acc + d_term;
    if (total > OUT_MAX) total = OUT_MAX;
    else if (total < OUT_MIN) total = OUT_MIN;
    return total[OUT_W-1:0];
  endfunction

  function automatic logic [GAIN_W-1:0] pick_gain();
    case ($urandom_range(4))
      0: return '0;
      1: return GAIN_MAX;
      2: return GAIN_W'($urandom_range(0, 1023));
      3: return GAIN_W'($urandom_range(0, 65535));
      default: return GAIN_W'($urandom());
    endcase
  endfunction

  // result checker and receiver stalls
  always @(posedge clk) begin
    logic signed [OUT_W-1:0] exp_out;
    if (!rst && result_valid && !result_stall) begin
      if (control_expected_q.size() == 0) begin
        $error("control_out: unexpected result, expected none, got %0d", control_out);
        error_count++;
      end else begin
        exp_out = control_expected_q.pop_front();
        if (control_out !== exp_out) begin
          $error("control_out mismatch: expected %0d, got %0d", exp_out, control_out);
          error_count++;
        end
      end
    end
    result_stall <= !quiet && ($urandom_range(99) < 27);
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Regression FAIL");
    $finish;
  end

  task automatic send_item(input logic signed [IN_W-1:0] sp,
                           input logic signed [IN_W-1:0] ms);
    int gap;
    if (!quiet && $urandom_range(99) < 27) begin
      item_valid <= 1'b0;
      gap = ($urandom_range(9) == 0) ? $urandom_range(1, 45) : $urandom_range(1, 3);
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    setpoint   <= sp;
    measured   <= ms;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    control_expected_q.push_back(next_control(sp, ms));
  endtask

  // hold off new items until every outstanding result is back
  task automatic wait_results();
    item_valid <= 1'b0;
    do @(posedge clk); while (control_expected_q.size() != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    case (idx)
      REG_PROP_GAIN:   gain_p      = val[GAIN_W-1:0];
      REG_INTEG_GAIN:  gain_i      = val[GAIN_W-1:0];
      REG_DERIV_GAIN:  gain_d      = val[GAIN_W-1:0];
      REG_STEP_TIME:   dt_q8       = val[DT_W-1:0];
      REG_INTEG_LIMIT: integ_bound = val[LIMIT_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic test_proportional();
    send_item('0, '0);
    wait_results();
    write_reg(REG_PROP_GAIN, 24'd256);
    send_item(IN_MAX, IN_MIN);
    send_item(IN_MIN, IN_MAX);
    send_item(16'sd100, 16'sd100);
    wait_results();
    write_reg(REG_PROP_GAIN, GAIN_MAX);
    send_item(IN_MAX, IN_MIN);
    send_item(IN_MIN, IN_MAX);
    wait_results();
  endtask

  task automatic test_integral_clamp();
    write_reg(REG_PROP_GAIN, '0);
    write_reg(REG_INTEG_GAIN, GAIN_MAX);
    // limit still at its reset value here
    send_item(16'sd1000, '0);
    send_item(-16'sd1000, '0);
    wait_results();
    write_reg(REG_INTEG_LIMIT, '0);
    send_item(16'sd5, '0);
    wait_results();
    write_reg(REG_INTEG_LIMIT, 24'd65535);
    write_reg(REG_INTEG_GAIN, 24'd1);
    write_reg(REG_STEP_TIME, 24'd100);
    // small increments truncate toward zero
    send_item(16'sd3, '0);
    send_item(-16'sd7, '0);
    send_item(IN_MIN, IN_MAX);
    wait_results();
  endtask

  task automatic test_derivative();
    write_reg(REG_INTEG_GAIN, '0);
    write_reg(REG_DERIV_GAIN, GAIN_MAX);
    write_reg(REG_STEP_TIME, 24'd1);
    // full-scale swings drive the sum into both saturation limits
    send_item(IN_MAX, IN_MIN);
    send_item(IN_MIN, IN_MAX);
    wait_results();
    write_reg(REG_STEP_TIME, 24'd4095);
    send_item(16'sd10, '0);
    send_item(-16'sd3, '0);
    wait_results();
    // zero dt behaves as one
    write_reg(REG_DERIV_GAIN, 24'd300);
    write_reg(REG_STEP_TIME, '0);
    send_item(16'sd5, '0);
    send_item('0, '0);
    wait_results();
  endtask

  task automatic test_register_masking();
    write_reg(REG_PROP_GAIN, 24'd77);
    write_reg(REG_INTEG_GAIN, 24'd512);
    write_reg(REG_STEP_TIME, 24'hFFF100);
    write_reg(REG_INTEG_LIMIT, 24'hAB0010);
    write_reg(REG_NONE, CFG_DATA_W'($urandom()));
    send_item(16'sd40, -16'sd40);
    send_item(16'sd40, -16'sd40);
    send_item(-16'sd12, 16'sd9);
    wait_results();
  endtask

  task automatic random_settings();
    logic [CFG_DATA_W-1:0] dt_val, lim_val;
    case ($urandom_range(3))
      0: dt_val = 24'd1;
      1: dt_val = 24'd4095;
      2: dt_val = 24'd256;
      default: dt_val = CFG_DATA_W'($urandom_range(1, 4095));
    endcase
    case ($urandom_range(3))
      0: lim_val = '0;
      1: lim_val = 24'd65535;
      default: lim_val = CFG_DATA_W'($urandom_range(0, 65535));
    endcase
    write_reg(REG_PROP_GAIN, pick_gain());
    write_reg(REG_INTEG_GAIN, pick_gain());
    write_reg(REG_DERIV_GAIN, pick_gain());
    write_reg(REG_STEP_TIME, dt_val);
    write_reg(REG_INTEG_LIMIT, lim_val);
  endtask

  task automatic random_items(input int count);
    logic signed [IN_W-1:0] sp, ms, target;
    logic [31:0] rnd;
    int m;
    target = IN_W'($urandom());
    for (int i = 0; i < count; i++) begin
      rnd = $urandom();
      if ($urandom_range(99) < 60) begin
        // tracking: measurement hovering around a fixed setpoint
        m  = int'(target) + int'($urandom_range(0, 200)) - 100;
        sp = target;
        ms = m[IN_W-1:0];
      end else if ($urandom_range(19) == 0) begin
        sp = rnd[0] ? IN_MAX : IN_MIN;
        ms = rnd[1] ? IN_MAX : IN_MIN;
      end else begin
        sp = rnd[15:0];
        ms = rnd[31:16];
      end
      send_item(sp, ms);
      if ($urandom_range(99) == 0) wait_results();
    end
    wait_results();
  endtask

  task automatic test_random_settings();
    for (int ph = 0; ph < 8; ph++) begin
      random_settings();
      random_items(125);
    end
  endtask

  task automatic test_back_to_back();
    quiet = 1'b1;
    write_reg(REG_PROP_GAIN, 24'd300);
    write_reg(REG_INTEG_GAIN, 24'd40);
    write_reg(REG_DERIV_GAIN, 24'd900);
    write_reg(REG_STEP_TIME, 24'd128);
    write_reg(REG_INTEG_LIMIT, 24'd2000);
    random_items(200);
    quiet = 1'b0;
  endtask

  initial begin
    gain_p      = '0;
    gain_i      = '0;
    gain_d      = '0;
    dt_q8       = STEP_TIME_RESET;
    integ_bound = INTEG_LIMIT_RESET;
    err_prev    = 0;
    integ_q8    = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_proportional();
    test_integral_clamp();
    test_derivative();
    test_register_masking();
    test_random_settings();
    test_back_to_back();
    wait_results();
    repeat (60) @(posedge clk);
    if (control_expected_q.size() != 0) begin
      $error("control_out: %0d expected results never arrived",
             control_expected_q.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/ppc_pkg.sv
rtl/ppc_mul.sv
rtl/ppc_div.sv
rtl/pid_position_controller.sv
bench/testbench.sv
